[sv/tccw_pkg.sv]
// Shared types, constants and helpers of the text console cell writer.
package tccw_pkg;

  localparam int ROWS       = 25;
  localparam int COLUMNS    = 80;
  localparam int CELL_COUNT = ROWS * COLUMNS;
  localparam int ROW_W      = 5;
  localparam int COL_W      = 7;
  localparam int CELL_W     = 16;
  localparam int ADDR_W     = $clog2(CELL_COUNT);
  localparam int CNT_W      = $clog2(CELL_COUNT + 1);
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [7:0] NEWLINE_CODE = 8'd10;

  typedef enum logic [1:0] {
    OP_PUT   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_SET   = 2'd2,
    OP_READ  = 2'd3
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FG_COLOR   = 2'd0,
    CFG_BG_COLOR   = 2'd1,
    CFG_BLANK_CHAR = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    op_e              op;
    logic [7:0]       char_code;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] column;
  } in_t;

  typedef struct packed {
    logic [ROW_W-1:0] cursor_row;
    logic [COL_W-1:0] cursor_column;
    logic [7:0]       cell_char;
    logic [7:0]       cell_attr;
  } out_t;

  // Control of the sweep counter: load a new range, or step through it.
  typedef struct packed {
    logic             load;
    logic             step;
    logic [CNT_W-1:0] start;
    logic [CNT_W-1:0] last;
  } sweep_ctrl_t;

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                  input logic [COL_W-1:0] col);
    logic [ADDR_W-1:0] base;
    base = ADDR_W'(row) * ADDR_W'(COLUMNS);
    return base + ADDR_W'(col);
  endfunction

endpackage

[sv/text_console_cell_writer_unit.sv]
// Top level of the text console cell writer: sequencer, cursor and cell store.
//
// A text screen of ROWS x COLUMNS cells (character in the low byte, attribute
// {bg_color, fg_color} in the high byte) with a cursor. Each request gives one
// result carrying the cursor after the operation and, for a read, the cell.
// Put-character and set-cursor are answered from the idle state; a read goes
// through a read state, since the cell store has a registered read port. Clear
// writes one cell per cycle through the shared sweep counter. A put-character
// or newline that runs past the last row scrolls the screen: the sweep copies
// every cell one row up (one read and one write per cycle) and then zeroes the
// bottom row before the result is given. After reset the block zeroes the whole
// store in a clearing pass, during which no request is taken; configuration
// writes are taken at any time and should only be made while the block is idle.
module text_console_cell_writer_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Request channel.
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  tccw_pkg::in_t                   in_req_i,
  // Result channel.
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output tccw_pkg::out_t                  out_res_o,
  // Configuration write channel.
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [tccw_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [tccw_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import tccw_pkg::*;

  typedef enum logic [5:0] {
    ST_INIT  = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_READ  = 6'b000100,
    ST_CLEAR = 6'b001000,
    ST_COPY  = 6'b010000,
    ST_ZERO  = 6'b100000
  } state_e;

  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);
  localparam logic [COL_W-1:0] LAST_COL = COL_W'(COLUMNS - 1);

  state_e state_q, state_d;

  logic [ROW_W-1:0] row_q, row_d;
  logic [COL_W-1:0] col_q, col_d;
  logic [3:0]       fg_q, bg_q;
  logic [7:0]       blank_q;
  logic             in_range_q, in_range_d;
  logic             pend_q;

  out_t out_q, out_d;
  logic out_valid_q;
  logic push;

  logic in_acc, out_acc;

  // Cell store ports.
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [CELL_W-1:0] ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [CELL_W-1:0] ram_rdata;

  // Sweep counter.
  sweep_ctrl_t      sw_ctrl;
  logic [CNT_W-1:0] sw_cnt;
  logic             sw_at_end;
  logic [CNT_W-1:0] copy_dst;

  // Cursor arithmetic for put-character.
  logic [ROW_W:0]   row_inc;
  logic [COL_W:0]   col_inc;
  logic             col_wrap;
  logic [ROW_W:0]   put_row;
  logic [COL_W-1:0] put_col;
  logic             put_scroll;
  logic [7:0]       attr;

  assign attr = {bg_q, fg_q};

  assign in_stall_o  = (state_q != ST_IDLE) || (out_valid_q && out_stall_i);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_acc     = out_valid_q && !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;
  assign cfg_ready_o = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fg_q    <= 4'd7;
      bg_q    <= 4'd0;
      blank_q <= 8'd32;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_FG_COLOR:   fg_q    <= cfg_data_i[3:0];
        CFG_BG_COLOR:   bg_q    <= cfg_data_i[3:0];
        CFG_BLANK_CHAR: blank_q <= cfg_data_i[7:0];
        default: begin
        end
      endcase
    end
  end

  // Where the cursor goes after a put-character, and whether that scrolls.
  always_comb begin
    row_inc  = {1'b0, row_q} + (ROW_W + 1)'(1);
    col_inc  = {1'b0, col_q} + (COL_W + 1)'(1);
    col_wrap = (col_inc == (COL_W + 1)'(COLUMNS));
    if (in_req_i.char_code == NEWLINE_CODE) begin
      put_row = row_inc;
      put_col = '0;
    end else if (col_wrap) begin
      put_row = row_inc;
      put_col = '0;
    end else begin
      put_row = {1'b0, row_q};
      put_col = col_inc[COL_W-1:0];
    end
    put_scroll = (put_row == (ROW_W + 1)'(ROWS));
  end

  // The copy pass writes each cell read in the previous cycle, one row up.
  assign copy_dst = sw_cnt - CNT_W'(COLUMNS + 1);

  always_comb begin
    state_d    = state_q;
    row_d      = row_q;
    col_d      = col_q;
    in_range_d = in_range_q;
    push       = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = sw_cnt[ADDR_W-1:0];
    ram_wdata  = '0;
    ram_raddr  = sw_cnt[ADDR_W-1:0];
    sw_ctrl    = '0;

    unique case (state_q)
      ST_INIT: begin
        // Power-on clearing pass: the store resets to zero cells.
        ram_we       = 1'b1;
        sw_ctrl.step = 1'b1;
        if (sw_at_end) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        ram_waddr = cell_addr(row_q, col_q);
        ram_wdata = {attr, in_req_i.char_code};
        ram_raddr = cell_addr(in_req_i.row, in_req_i.column);
        if (in_acc) begin
          unique case (in_req_i.op)
            OP_PUT: begin
              ram_we = (in_req_i.char_code != NEWLINE_CODE);
              col_d  = put_col;
              if (put_scroll) begin
                row_d         = LAST_ROW;
                sw_ctrl.load  = 1'b1;
                sw_ctrl.start = CNT_W'(COLUMNS);
                sw_ctrl.last  = CNT_W'(CELL_COUNT);
                state_d       = ST_COPY;
              end else begin
                row_d = put_row[ROW_W-1:0];
                push  = 1'b1;
              end
            end
            OP_CLEAR: begin
              row_d         = '0;
              col_d         = '0;
              sw_ctrl.load  = 1'b1;
              sw_ctrl.start = '0;
              sw_ctrl.last  = CNT_W'(CELL_COUNT - 1);
              state_d       = ST_CLEAR;
            end
            OP_SET: begin
              // Out-of-range coordinates saturate to the last row or column.
              row_d = ({1'b0, in_req_i.row} >= (ROW_W + 1)'(ROWS)) ?
                      LAST_ROW : in_req_i.row;
              col_d = ({1'b0, in_req_i.column} >= (COL_W + 1)'(COLUMNS)) ?
                      LAST_COL : in_req_i.column;
              push  = 1'b1;
            end
            OP_READ: begin
              in_range_d = ({1'b0, in_req_i.row} < (ROW_W + 1)'(ROWS)) &&
                           ({1'b0, in_req_i.column} < (COL_W + 1)'(COLUMNS));
              state_d    = ST_READ;
            end
            default: begin
            end
          endcase
        end
      end

      ST_READ: begin
        push    = 1'b1;
        state_d = ST_IDLE;
      end

      ST_CLEAR: begin
        ram_we       = 1'b1;
        ram_wdata    = {attr, blank_q};
        sw_ctrl.step = 1'b1;
        if (sw_at_end) begin
          push    = 1'b1;
          state_d = ST_IDLE;
        end
      end

      ST_COPY: begin
        // Read the cell at the counter while writing the previous read one
        // row up; the counter runs one past the end to drain the last cell.
        ram_we       = pend_q;
        ram_waddr    = copy_dst[ADDR_W-1:0];
        ram_wdata    = ram_rdata;
        sw_ctrl.step = 1'b1;
        if (sw_at_end) begin
          sw_ctrl.load  = 1'b1;
          sw_ctrl.start = CNT_W'(CELL_COUNT - COLUMNS);
          sw_ctrl.last  = CNT_W'(CELL_COUNT - 1);
          state_d       = ST_ZERO;
        end
      end

      ST_ZERO: begin
        ram_we       = 1'b1;
        sw_ctrl.step = 1'b1;
        if (sw_at_end) begin
          push    = 1'b1;
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    out_d.cursor_row    = row_d;
    out_d.cursor_column = col_d;
    if ((state_q == ST_READ) && in_range_q) begin
      out_d.cell_char = ram_rdata[7:0];
      out_d.cell_attr = ram_rdata[15:8];
    end else begin
      out_d.cell_char = '0;
      out_d.cell_attr = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      row_q       <= '0;
      col_q       <= '0;
      in_range_q  <= 1'b0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      row_q      <= row_d;
      col_q      <= col_d;
      in_range_q <= in_range_d;
      pend_q     <= (state_q == ST_COPY);
      if (push) begin
        out_valid_q <= 1'b1;
      end else if (out_acc) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // The result payload needs no reset; it is qualified by its valid bit.
  always_ff @(posedge clk_i) begin
    if (push) begin
      out_q <= out_d;
    end
  end

  tccw_sweep u_sweep (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (sw_ctrl),
    .cnt_o    (sw_cnt),
    .at_end_o (sw_at_end)
  );

  tccw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELL_COUNT)
  ) u_cells (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule

[sv/tccw_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
module tccw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[sv/tccw_sweep.sv]
// Shared address counter that walks a range of cells for the power-on pass, clear and scroll.
module tccw_sweep (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  tccw_pkg::sweep_ctrl_t       ctrl_i,
  output logic [tccw_pkg::CNT_W-1:0]  cnt_o,
  output logic                        at_end_o
);
  import tccw_pkg::*;

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [CNT_W-1:0] last_q, last_d;

  // After reset the counter is set up for the power-on clearing pass.
  always_comb begin
    cnt_d  = cnt_q;
    last_d = last_q;
    if (ctrl_i.load) begin
      cnt_d  = ctrl_i.start;
      last_d = ctrl_i.last;
    end else if (ctrl_i.step) begin
      cnt_d = cnt_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      last_q <= CNT_W'(CELL_COUNT - 1);
    end else begin
      cnt_q  <= cnt_d;
      last_q <= last_d;
    end
  end

  assign cnt_o    = cnt_q;
  assign at_end_o = (cnt_q == last_q);

endmodule
